// File: src/dirc_pkg.sv
// ----------------------------------------------------------------------------
// Decimal integer range check package
// Shared types, codes and limit tables for the decimal range checker.
// ----------------------------------------------------------------------------
package dirc_pkg;

    // Check mode codes; the unused fourth code behaves as the unsigned mode.
    localparam logic [1:0] MODE_S32      = 2'd0;
    localparam logic [1:0] MODE_S64      = 2'd1;
    localparam logic [1:0] MODE_UNSIGNED = 2'd2;

    // Digit counts of the signed limits and the saturation point of the count.
    localparam logic [4:0] LEN32      = 5'd10;
    localparam logic [4:0] LEN64      = 5'd19;
    localparam logic [4:0] DIGITS_SAT = 5'd20;

    // Limits in BCD, most significant digit first in the highest nibble.
    localparam logic [75:0] LIM32_NEG = 76'h2147483648;
    localparam logic [75:0] LIM32_POS = 76'h2147483647;
    localparam logic [75:0] LIM64_NEG = 76'h9223372036854775808;
    localparam logic [75:0] LIM64_POS = 76'h9223372036854775807;

    // Character codes that the scanner treats specially.
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_ONE   = 8'd49;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Scan phase, one-hot.
    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_ZEROS  = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_TRAIL  = 4'b1000
    } dirc_phase_t;

    // Result of the digit-by-digit comparison against the limit.
    typedef enum logic [1:0] {
        CMP_EQ      = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } dirc_cmp_t;

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } dirc_item_t;

    // Returns the limit digit at position idx for the given mode and sign.
    function automatic logic [3:0] limit_digit(input logic [1:0] mode,
                                               input logic       neg,
                                               input logic [4:0] idx);
        logic [75:0] lim;
        logic [4:0]  len;
        logic [4:0]  pos;
        logic [75:0] shifted;
        if (mode == MODE_S32) begin
            lim = neg ? LIM32_NEG : LIM32_POS;
            len = LEN32;
        end else begin
            lim = neg ? LIM64_NEG : LIM64_POS;
            len = LEN64;
        end
        pos     = len - 5'd1 - idx;
        shifted = lim >> {pos, 2'b00};
        return shifted[3:0];
    endfunction

endpackage

// File: src/dirc_scan.sv
// ----------------------------------------------------------------------------
// Decimal integer range check scanner
// Holds the per-string scan state, advances it by one character per word and
// produces the verdict when the word that closes the string is processed.
// ----------------------------------------------------------------------------
module dirc_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  dirc_pkg::dirc_item_t item,
    input  logic [1:0]        check_mode,
    output logic              verdict
);
    import dirc_pkg::*;

    dirc_phase_t phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [4:0]  count_reg, count_next;
    dirc_cmp_t   cmp_reg, cmp_next;
    logic        rej_reg, rej_next;
    logic        seen_reg, seen_next;

    logic        is_space;
    logic        is_sign;
    logic        is_nonzero;
    logic        signed_mode;
    logic        take_sig;
    logic [4:0]  len;
    logic [7:0]  lim_char;

    // Character classes.
    assign is_space   = (item.char_code == CH_SPACE) ||
                        ((item.char_code >= CH_TAB) && (item.char_code <= CH_CR));
    assign is_sign    = (item.char_code == CH_PLUS) || (item.char_code == CH_MINUS);
    assign is_nonzero = (item.char_code >= CH_ONE) && (item.char_code <= CH_NINE);
    assign signed_mode = (check_mode == MODE_S32) || (check_mode == MODE_S64);
    assign len        = (check_mode == MODE_S32) ? LEN32 : LEN64;
    assign lim_char   = {4'h3, limit_digit(check_mode, neg_reg, count_reg)};

    // Next scan state for the current character.
    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        cmp_next   = cmp_reg;
        rej_next   = rej_reg;
        seen_next  = seen_reg;
        take_sig   = 1'b0;
        if (item.has_char) begin
            seen_next = 1'b1;
            if (!rej_reg) begin
                if (is_space) begin
                    if (phase_reg != PH_LEAD) begin
                        phase_next = PH_TRAIL;
                    end
                end else if (phase_reg == PH_TRAIL) begin
                    rej_next = 1'b1;
                end else if (is_sign) begin
                    if (phase_reg == PH_LEAD) begin
                        neg_next   = neg_reg | (item.char_code == CH_MINUS);
                        phase_next = PH_ZEROS;
                    end else begin
                        rej_next = 1'b1;
                    end
                end else if (item.char_code == CH_ZERO) begin
                    if (phase_reg == PH_DIGITS) begin
                        take_sig = 1'b1;
                    end else begin
                        phase_next = PH_ZEROS;
                    end
                end else if (is_nonzero) begin
                    take_sig = 1'b1;
                end else begin
                    rej_next = 1'b1;
                end
            end
        end
        // A significant digit: compare against the limit while still equal.
        if (take_sig) begin
            if (signed_mode && (count_reg < len) && (cmp_reg == CMP_EQ)) begin
                if (item.char_code < lim_char) begin
                    cmp_next = CMP_LESS;
                end else if (item.char_code > lim_char) begin
                    cmp_next = CMP_GREATER;
                end
            end
            if (count_reg < DIGITS_SAT) begin
                count_next = count_reg + 5'd1;
            end
            phase_next = PH_DIGITS;
        end
    end

    // Verdict on the string including the current character.
    always_comb begin
        if (!seen_next || rej_next) begin
            verdict = 1'b0;
        end else if (!signed_mode) begin
            verdict = (phase_next != PH_LEAD) && !neg_next;
        end else if (count_next > len) begin
            verdict = 1'b0;
        end else if ((count_next == len) && (cmp_next == CMP_GREATER)) begin
            verdict = 1'b0;
        end else begin
            verdict = 1'b1;
        end
    end

    // State registers; a closing word returns everything to the start state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            count_reg <= 5'd0;
            cmp_reg   <= CMP_EQ;
            rej_reg   <= 1'b0;
            seen_reg  <= 1'b0;
        end else if (step) begin
            if (item.last) begin
                phase_reg <= PH_LEAD;
                neg_reg   <= 1'b0;
                count_reg <= 5'd0;
                cmp_reg   <= CMP_EQ;
                rej_reg   <= 1'b0;
                seen_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                count_reg <= count_next;
                cmp_reg   <= cmp_next;
                rej_reg   <= rej_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

// File: src/dirc_out_reg.sv
// ----------------------------------------------------------------------------
// Decimal integer range check output register
// Holds one verdict word until the downstream side takes it.
// ----------------------------------------------------------------------------
module dirc_out_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  logic       verdict,
    output logic       can_load,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [0] accepted, [7:1] zero
);
    import dirc_pkg::*;

    logic valid_reg;
    logic data_reg;

    // The register can take a new word when empty or when being drained.
    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, data_reg};

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= verdict;
        end
    end

endmodule

// File: src/decimal_integer_range_check.sv
// ----------------------------------------------------------------------------
// Decimal integer range check
// Checks a character stream for a valid signed or unsigned decimal integer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one character per word: s_tdata holds the
//   character code, s_tuser[0] says whether the word carries a character,
//   and s_tlast closes the string. The master channel returns one word per
//   string, on the word with s_tlast set; m_tdata[0] is 1 when the string
//   is a valid number for the mode in cfg_wr_data (0 = 32-bit signed,
//   1 = 64-bit signed, 2 or 3 = non-negative digits). The user must see
//   that the mode is written only while no string is in progress; the
//   block itself does not enforce this. A closing word waits in the input
//   register, then passes through the scan logic into the output register,
//   which raises m_tvalid. One word is accepted per cycle while no closing
//   word is held back. A stalled receiver holds back a closing word and
//   the words behind it; other characters keep flowing.
//   Reset clears the scan state, both valid flags and the mode (to 0).
// ----------------------------------------------------------------------------
module decimal_integer_range_check (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,   // check_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] char_code
    input  logic [0:0] s_tuser,       // [0] has_char
    input  logic       s_tlast,       // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata        // [0] accepted, [7:1] zero
);
    import dirc_pkg::*;

    logic       close_held;
    logic [1:0] check_mode_reg;
    logic       in_valid_reg;
    dirc_item_t item_reg;
    logic       out_free;
    logic       advance;
    logic       verdict;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_mode_reg <= MODE_S32;
        end else if (cfg_wr_en) begin
            check_mode_reg <= cfg_wr_data;
        end
    end

    // Flag for a pending closing word, used only for checking flow.
    assign close_held = in_valid_reg && item_reg.last;

    // A held word moves on unless it closes a string and the output is full.
    assign advance  = in_valid_reg && (!item_reg.last || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.char_code <= s_tdata;
            item_reg.has_char  <= s_tuser[0];
            item_reg.last      <= s_tlast;
        end
    end

    dirc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (item_reg),
        .check_mode (check_mode_reg),
        .verdict    (verdict)
    );

    dirc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && item_reg.last),
        .verdict  (verdict),
        .can_load (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A processed closing word always shows up as a result next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.last) |=> m_tvalid)
        else $error("closing word processed without a result");

    // A held closing word waits only while the output register is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (close_held && !advance) |-> (m_tvalid && !m_tready))
        else $error("closing word stalled with a free output register");

    // A word that is not taken stays in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held word lost from the input register");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

// File: bench/tb_decimal_integer_range_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal integer range check testbench
// Streams character strings into the checker and compares each verdict with
// a cycle-free model of the scanner kept inside the bench. The directed tests
// cover the awkward strings and both limits of each signed range. The random
// test mixes well-formed numbers near the limits with damaged strings and
// plain byte noise, across several check modes. Both stream sides stall at
// random, except during one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_decimal_integer_range_check;

    import dirc_pkg::*;

    // The spare mode code behaves as the unsigned mode.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1020;
    localparam int REPORT_LIMIT = 10;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic [0:0] s_tuser = 1'b0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    // Decimal text of the signed limits, most significant digit first.
    string lim32_neg_txt = "2147483648";
    string lim32_pos_txt = "2147483647";
    string lim64_neg_txt = "9223372036854775808";
    string lim64_pos_txt = "9223372036854775807";

    // Scanner copy kept by the bench.
    logic [1:0]  check_mode_q = MODE_S32;
    dirc_phase_t scan_phase = PH_LEAD;
    logic        scan_neg = 1'b0;
    logic [4:0]  sig_digits = 5'd0;
    dirc_cmp_t   limit_cmp = CMP_EQ;
    logic        scan_bad = 1'b0;
    logic        scan_seen = 1'b0;

    logic [7:0]   expected_verdicts[$];
    byte unsigned text_buf[$];
    logic [7:0]   want_word;
    int           fail_count = 0;
    int           items_sent = 0;
    bit           steady = 1'b0;

    decimal_integer_range_check dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------------

    function automatic void clear_scan();
        scan_phase = PH_LEAD;
        scan_neg   = 1'b0;
        sig_digits = 5'd0;
        limit_cmp  = CMP_EQ;
        scan_bad   = 1'b0;
        scan_seen  = 1'b0;
    endfunction

    function automatic bit is_blank(input byte unsigned c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Compares one significant digit with the limit digit at the same place.
    function automatic void count_digit(input byte unsigned c);
        int           span;
        string        lim;
        byte unsigned lc;
        span = 0;
        if (check_mode_q == MODE_S32) begin
            lim  = scan_neg ? lim32_neg_txt : lim32_pos_txt;
            span = LEN32;
        end else if (check_mode_q == MODE_S64) begin
            lim  = scan_neg ? lim64_neg_txt : lim64_pos_txt;
            span = LEN64;
        end
        if (sig_digits < span && limit_cmp == CMP_EQ) begin
            lc = lim[sig_digits];
            if (c < lc) begin
                limit_cmp = CMP_LESS;
            end else if (c > lc) begin
                limit_cmp = CMP_GREATER;
            end
        end
        if (sig_digits < DIGITS_SAT) begin
            sig_digits = sig_digits + 5'd1;
        end
        scan_phase = PH_DIGITS;
    endfunction

    function automatic void scan_char(input byte unsigned c);
        scan_seen = 1'b1;
        if (scan_bad) return;
        if (is_blank(c)) begin
            if (scan_phase != PH_LEAD) scan_phase = PH_TRAIL;
            return;
        end
        if (scan_phase == PH_TRAIL) begin
            scan_bad = 1'b1;
            return;
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
            if (scan_phase == PH_LEAD) begin
                if (c == CH_MINUS) scan_neg = 1'b1;
                scan_phase = PH_ZEROS;
            end else begin
                scan_bad = 1'b1;
            end
            return;
        end
        // A zero before the first significant digit is only a leading zero.
        if (c == CH_ZERO && scan_phase != PH_DIGITS) begin
            scan_phase = PH_ZEROS;
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            count_digit(c);
            return;
        end
        scan_bad = 1'b1;
    endfunction

    function automatic logic range_verdict();
        int span;
        if (!scan_seen || scan_bad) return 1'b0;
        if (check_mode_q >= MODE_UNSIGNED) begin
            return scan_phase != PH_LEAD && !scan_neg;
        end
        span = (check_mode_q == MODE_S32) ? LEN32 : LEN64;
        if (sig_digits > span) return 1'b0;
        if (sig_digits == span && limit_cmp == CMP_GREATER) return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers; each returns right after a rising edge.
    // ------------------------------------------------------------------------

    // Sends one word and updates the model once it is taken.
    task automatic push_item(input byte unsigned c, input bit has, input bit fin);
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= c;
        s_tuser[0] <= has;
        s_tlast    <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (has) scan_char(c);
        if (fin) begin
            expected_verdicts.push_back({7'd0, range_verdict()});
            clear_scan();
        end
    endtask

    // Sends the text buffer as one string. With sprinkle set, words without a
    // character are mixed in and the string is sometimes closed by one.
    task automatic send_text(input bit sprinkle);
        int i;
        bit void_close;
        void_close = sprinkle && $urandom_range(0, 4) == 0;
        if (text_buf.size() == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            for (i = 0; i < text_buf.size(); i++) begin
                if (sprinkle && $urandom_range(0, 19) == 0) begin
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                push_item(text_buf[i], 1'b1, !void_close && i == text_buf.size() - 1);
            end
            if (void_close) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic send_str(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text(1'b0);
    endtask

    // Waits until every verdict is back and the pipeline has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        check_mode_q = mode;
    endtask

    function automatic byte unsigned rand_blank();
        int v;
        v = $urandom_range(8, 13);
        return (v == 8) ? CH_SPACE : 8'(v);
    endfunction

    // Builds a mostly well-formed number, often close to a signed limit.
    function automatic void build_number();
        int    pick;
        int    span;
        int    pos;
        int    i;
        bit    neg;
        string lim;
        text_buf.delete();
        repeat ($urandom_range(0, 2)) text_buf.push_back(rand_blank());
        pick = $urandom_range(0, 9);
        neg  = 1'b0;
        if (pick < 3) begin
            text_buf.push_back(CH_PLUS);
        end else if (pick < 6) begin
            text_buf.push_back(CH_MINUS);
            neg = 1'b1;
        end
        repeat ($urandom_range(0, 2)) text_buf.push_back(CH_ZERO);
        pick = $urandom_range(0, 9);
        if (pick >= 4 && pick <= 7) begin
            // Limit text, perhaps with one digit changed or one more or less.
            if (pick < 6) begin
                lim = neg ? lim32_neg_txt : lim32_pos_txt;
            end else begin
                lim = neg ? lim64_neg_txt : lim64_pos_txt;
            end
            pos = text_buf.size();
            for (i = 0; i < lim.len(); i++) text_buf.push_back(lim[i]);
            if ($urandom_range(0, 2) != 0) begin
                i = $urandom_range(0, lim.len() - 1);
                text_buf[pos + i] = (i == 0) ? 8'($urandom_range(CH_ONE, CH_NINE))
                                             : 8'($urandom_range(CH_ZERO, CH_NINE));
            end
            case ($urandom_range(0, 4))
                0: begin
                    void'(text_buf.pop_back());
                end
                1: begin
                    text_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                end
                default: begin
                end
            endcase
        end else begin
            if (pick < 4) begin
                span = $urandom_range(0, 6);
            end else if (pick == 8) begin
                span = $urandom_range(9, 22);
            end else begin
                span = $urandom_range(20, 30);
            end
            for (i = 0; i < span; i++) begin
                text_buf.push_back((i == 0) ? 8'($urandom_range(CH_ONE, CH_NINE))
                                            : 8'($urandom_range(CH_ZERO, CH_NINE)));
            end
        end
        repeat ($urandom_range(0, 2)) text_buf.push_back(rand_blank());
        // Now and then one character is damaged.
        if ($urandom_range(0, 6) == 0) begin
            if (text_buf.size() == 0) text_buf.push_back(CH_ZERO);
            pos = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: text_buf[pos] = CH_PLUS;
                1: text_buf[pos] = CH_MINUS;
                2: text_buf[pos] = CH_SPACE;
                default: text_buf[pos] = 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    function automatic void build_noise();
        text_buf.delete();
        repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_odd_strings();
        set_mode(MODE_S32);
        send_str("");
        send_str(" \t\r ");
        send_str("+");
        send_str("-");
        send_str("000");
        send_str("-000");
        send_str("12 3");
        send_str(" 42 \n");
        send_str("+-1");
        send_str("1+");
        // A NUL byte and a top-bit byte are ordinary non-digits.
        text_buf.delete();
        text_buf.push_back(CH_NINE);
        text_buf.push_back(8'h00);
        send_text(1'b0);
        text_buf[1] = 8'hFF;
        send_text(1'b0);
        // Words without a character are skipped; one closes the string.
        push_item(CH_ONE, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(CH_NINE, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_limits_32();
        set_mode(MODE_S32);
        send_str("2147483647");
        send_str("2147483648");
        send_str("-2147483648");
        send_str("-2147483649");
        send_str("+2147483646");
        send_str("0002147483647");
        send_str("10000000000");
        send_str("999999999");
        settle();
    endtask

    task automatic test_limits_64();
        set_mode(MODE_S64);
        send_str("9223372036854775807");
        send_str("9223372036854775808");
        send_str("-9223372036854775808");
        send_str("-9223372036854775809");
        send_str("2147483648");
        send_str("99999999999999999999");
        send_str("1234567890123456789012345");
        settle();
    endtask

    task automatic test_unsigned_modes();
        set_mode(MODE_UNSIGNED);
        send_str("+");
        send_str("-");
        send_str("  ");
        send_str("");
        send_str("-0");
        send_str("+0007");
        send_str("123456789012345678901234567890");
        settle();
        set_mode(MODE_SPARE);
        send_str("-5");
        send_str("  88  ");
        send_str("99999999999999999999999");
        settle();
    endtask

    task automatic test_random_strings();
        int start;
        int round;
        start = items_sent;
        round = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            settle();
            set_mode(2'($urandom_range(0, 3)));
            steady = (round == 2);
            repeat (25) begin
                if (items_sent - start >= RANDOM_ITEMS) break;
                if ($urandom_range(0, 9) == 0) begin
                    build_noise();
                end else begin
                    build_number();
                end
                send_text(1'b1);
            end
            round++;
        end
        steady = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and the comparison of each verdict word.
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("unexpected verdict word %h", m_tdata);
                end
                fail_count++;
            end else begin
                want_word = expected_verdicts.pop_front();
                if (m_tdata !== want_word) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("verdict mismatch: expected %h, got %h", want_word, m_tdata);
                    end
                    fail_count++;
                end
            end
        end
        m_tready <= steady || $urandom_range(0, 99) >= 9;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_odd_strings();
        test_limits_32();
        test_limits_64();
        test_unsigned_modes();
        test_random_strings();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
src/dirc_pkg.sv
src/dirc_scan.sv
src/dirc_out_reg.sv
src/decimal_integer_range_check.sv
bench/tb_decimal_integer_range_check.sv
